// ===== hdl/rss_pkg.sv =====
// ----------------------------------------------------------------------------
// rss_pkg
// shared types and constants for the record stack with exchange sort
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_LIST = 2'd2,
        ACT_SORT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_RECORD = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_LIST_RD,
        S_LIST_EMIT,
        S_SORT_RDA,
        S_SORT_LDA,
        S_SORT_RDB,
        S_SORT_CMP,
        S_SORT_WRA
    } state_t;

    typedef struct packed {
        logic signed [31:0] id;
        logic signed [15:0] score;
        logic        [63:0] name;
    } record_t;

    localparam int REC_W = $bits(record_t);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        record_t           wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic    done;
        status_t status;
        record_t rec;
        logic    last;
    } res_t;

endpackage

// ===== hdl/rss_ram.sv =====
// ----------------------------------------------------------------------------
// rss_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rss_ctrl.sv =====
// ----------------------------------------------------------------------------
// rss_ctrl
// sequencer for push, pop, list and in-place exchange sort over the record ram
// ----------------------------------------------------------------------------
module rss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rss_pkg::action_t  action,
    input  rss_pkg::record_t  in_rec,
    input  rss_pkg::record_t  rdata,
    output logic              busy,
    output rss_pkg::mem_req_t mem,
    output rss_pkg::res_t     res
);

    rss_pkg::state_t                state_reg, state_next;
    logic [rss_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [rss_pkg::ADDR_W-1:0]     a_reg, a_next;
    logic [rss_pkg::CNT_W-1:0]      b_reg, b_next;
    logic [rss_pkg::ADDR_W-1:0]     idx_reg, idx_next;
    rss_pkg::record_t               reca_reg, reca_next;
    logic                           done_reg, done_next;
    rss_pkg::status_t               status_reg, status_next;
    rss_pkg::record_t               rec_reg, rec_next;
    logic                           last_reg, last_next;

    logic                           accept;
    logic                           full;
    logic                           empty;
    logic [rss_pkg::CNT_W-1:0]      cnt_m1;
    logic [rss_pkg::CNT_W-1:0]      b_inc;
    logic [rss_pkg::CNT_W-1:0]      a_plus2;

    assign accept  = start && (state_reg == rss_pkg::S_IDLE);
    assign full    = (count_reg == rss_pkg::CNT_W'(rss_pkg::DEPTH));
    assign empty   = (count_reg == '0);
    assign cnt_m1  = count_reg - rss_pkg::CNT_W'(1);
    assign b_inc   = b_reg + rss_pkg::CNT_W'(1);
    assign a_plus2 = rss_pkg::CNT_W'(a_reg) + rss_pkg::CNT_W'(2);
    assign busy    = (state_reg != rss_pkg::S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rss_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        rss_pkg::ACT_PUSH: state_next = rss_pkg::S_IDLE;
                        rss_pkg::ACT_POP:
                            state_next = empty ? rss_pkg::S_IDLE : rss_pkg::S_POP;
                        rss_pkg::ACT_LIST:
                            state_next = empty ? rss_pkg::S_IDLE : rss_pkg::S_LIST_RD;
                        rss_pkg::ACT_SORT:
                        begin
                            if (empty)
                                state_next = rss_pkg::S_IDLE;
                            else if (count_reg == rss_pkg::CNT_W'(1))
                                state_next = rss_pkg::S_LIST_RD;
                            else
                                state_next = rss_pkg::S_SORT_RDA;
                        end
                        default: state_next = rss_pkg::S_IDLE;
                    endcase
                end
            end
            rss_pkg::S_POP:       state_next = rss_pkg::S_IDLE;
            rss_pkg::S_LIST_RD:   state_next = rss_pkg::S_LIST_EMIT;
            rss_pkg::S_LIST_EMIT:
                state_next = (idx_reg == '0) ? rss_pkg::S_IDLE : rss_pkg::S_LIST_RD;
            rss_pkg::S_SORT_RDA:  state_next = rss_pkg::S_SORT_LDA;
            rss_pkg::S_SORT_LDA:  state_next = rss_pkg::S_SORT_RDB;
            rss_pkg::S_SORT_RDB:  state_next = rss_pkg::S_SORT_CMP;
            rss_pkg::S_SORT_CMP:
                state_next = (b_inc < count_reg) ? rss_pkg::S_SORT_RDB
                                                 : rss_pkg::S_SORT_WRA;
            rss_pkg::S_SORT_WRA:
                state_next = (a_plus2 < count_reg) ? rss_pkg::S_SORT_RDA
                                                   : rss_pkg::S_LIST_RD;
            default:              state_next = rss_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next  = count_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        idx_next    = idx_reg;
        reca_next   = reca_reg;
        mem.we      = 1'b0;
        mem.waddr   = a_reg;
        mem.wdata   = reca_reg;
        mem.raddr   = idx_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rec_next    = rec_reg;
        last_next   = last_reg;
        unique case (state_reg)
            rss_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    last_next   = 1'b1;
                    rec_next    = '0;
                    status_next = rss_pkg::ST_EMPTY;
                    mem.raddr   = cnt_m1[rss_pkg::ADDR_W-1:0];
                    unique case (action)
                        rss_pkg::ACT_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = rss_pkg::ST_FULL;
                            end
                            else
                            begin
                                status_next = rss_pkg::ST_PUSHED;
                                mem.we      = 1'b1;
                                mem.waddr   = count_reg[rss_pkg::ADDR_W-1:0];
                                mem.wdata   = in_rec;
                                count_next  = count_reg + rss_pkg::CNT_W'(1);
                            end
                        end
                        rss_pkg::ACT_POP:
                        begin
                            if (!empty)
                            begin
                                done_next  = 1'b0;
                                count_next = cnt_m1;
                            end
                        end
                        rss_pkg::ACT_LIST,
                        rss_pkg::ACT_SORT:
                        begin
                            if (!empty)
                            begin
                                done_next = 1'b0;
                                idx_next  = cnt_m1[rss_pkg::ADDR_W-1:0];
                                a_next    = '0;
                            end
                        end
                        default: done_next = 1'b1;
                    endcase
                end
            end
            rss_pkg::S_POP:
            begin
                done_next   = 1'b1;
                status_next = rss_pkg::ST_RECORD;
                rec_next    = rdata;
                last_next   = 1'b1;
            end
            rss_pkg::S_LIST_RD:
            begin
                mem.raddr = idx_reg;
            end
            rss_pkg::S_LIST_EMIT:
            begin
                done_next   = 1'b1;
                status_next = rss_pkg::ST_RECORD;
                rec_next    = rdata;
                last_next   = (idx_reg == '0);
                idx_next    = idx_reg - rss_pkg::ADDR_W'(1);
            end
            rss_pkg::S_SORT_RDA:
            begin
                mem.raddr = a_reg;
            end
            rss_pkg::S_SORT_LDA:
            begin
                // position i is held in reca_reg for the whole inner pass
                reca_next = rdata;
                b_next    = rss_pkg::CNT_W'(a_reg) + rss_pkg::CNT_W'(1);
            end
            rss_pkg::S_SORT_RDB:
            begin
                mem.raddr = b_reg[rss_pkg::ADDR_W-1:0];
            end
            rss_pkg::S_SORT_CMP:
            begin
                if (rdata.score > reca_reg.score)
                begin
                    mem.we    = 1'b1;
                    mem.waddr = b_reg[rss_pkg::ADDR_W-1:0];
                    mem.wdata = reca_reg;
                    reca_next = rdata;
                end
                b_next = b_inc;
            end
            rss_pkg::S_SORT_WRA:
            begin
                mem.we    = 1'b1;
                mem.waddr = a_reg;
                mem.wdata = reca_reg;
                a_next    = a_reg + rss_pkg::ADDR_W'(1);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rss_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        idx_reg    <= idx_next;
        reca_reg   <= reca_next;
        status_reg <= status_next;
        rec_reg    <= rec_next;
        last_reg   <= last_next;
    end

    assign res.done   = done_reg;
    assign res.status = status_reg;
    assign res.rec    = rec_reg;
    assign res.last   = last_reg;

endmodule

// ===== hdl/record_stack_with_sort.sv =====
// ----------------------------------------------------------------------------
// record_stack_with_sort
// bounded stack of records with pop, top-down listing and exchange sort
// ----------------------------------------------------------------------------
// push: result in the cycle after accept; pop: top read in S_POP, then returned
// list: top-down, each record read in S_LIST_RD, returned from S_LIST_EMIT
// sort: for i = 0..n-2 load entry i, compare later entries, store it; then list
// these steps are set by the single read port of the record ram
// reset clears the entry count and the sequencer; the ram is not cleared
// results are strobed on done for one cycle and cannot be stalled
module record_stack_with_sort (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic        [1:0]  action,
    input  logic signed [31:0] student_id,
    input  logic signed [15:0] score,
    input  logic        [63:0] name_tag,
    output logic               done,
    output logic        [1:0]  status,
    output logic signed [31:0] student_id_res,
    output logic signed [15:0] score_out,
    output logic        [63:0] name_out,
    output logic               last
);

    rss_pkg::record_t               in_rec;
    rss_pkg::record_t               rd_rec;
    rss_pkg::mem_req_t              mem;
    rss_pkg::res_t                  res;
    logic [rss_pkg::REC_W-1:0]      ram_rdata;

    assign in_rec.id    = student_id;
    assign in_rec.score = score;
    assign in_rec.name  = name_tag;
    assign rd_rec       = rss_pkg::record_t'(ram_rdata);

    rss_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (rss_pkg::action_t'(action)),
        .in_rec (in_rec),
        .rdata  (rd_rec),
        .busy   (busy),
        .mem    (mem),
        .res    (res)
    );

    rss_ram #(
        .WIDTH (rss_pkg::REC_W),
        .DEPTH (rss_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (ram_rdata)
    );

    assign done           = res.done;
    assign status         = res.status;
    assign student_id_res = res.rec.id;
    assign score_out      = res.rec.score;
    assign name_out       = res.rec.name;
    assign last           = res.last;

`ifndef ASSERT_OFF
    // a beat without a record always closes the run
    a_norec_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != rss_pkg::ST_RECORD) |-> last)
        else $error("non-record beat without last");

    // an accepted command either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted command made no progress");

    // more beats follow a beat that is not the last
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> busy)
        else $error("run ended without a last beat");
`endif

endmodule
